>>> design/fmre_pkg.sv
// ----------------------------------------------------------------------------
// fmre_pkg
// Shared types and codes for the first monotonic run extractor: the input
// and result beat layouts, the run direction and the search phase.
// ----------------------------------------------------------------------------
package fmre_pkg;

  localparam int SAMPLE_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    end_of_sequence;
  } in_t;

  typedef struct packed {
    sample_t run_value;
    logic    run_end;
    logic    no_run_found;
  } out_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_RUN    = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

endpackage

>>> design/fmre_result_queue.sv
// ----------------------------------------------------------------------------
// fmre_result_queue
// Result queue: takes up to MAX_WR beats per cycle at consecutive slots and
// hands them out one per cycle while pop is high, oldest first.
// ----------------------------------------------------------------------------
module fmre_result_queue #(
  parameter int MAX_WR = 3,
  parameter int DEPTH  = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(MAX_WR+1)-1:0]  push_count,
  input  fmre_pkg::out_t               push_beats [MAX_WR],
  input  logic                         pop,
  output fmre_pkg::out_t               head,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  import fmre_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_WR+1);
  localparam int QW = $clog2(DEPTH+1);

  out_t          mem [DEPTH];
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [QW-1:0] level_next;
  logic [PW-1:0] widx [MAX_WR];

  // slot index modulo depth, input known to stay below twice the depth
  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    logic [PW:0] r;
    r = s;
    if (s >= (PW+1)'(DEPTH)) begin
      r = s - (PW+1)'(DEPTH);
    end
    return r[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < MAX_WR; k++) begin
      widx[k] = wrap({1'b0, wr_ptr} + (PW+1)'(k));
    end
    wr_ptr_next = wrap({1'b0, wr_ptr} + (PW+1)'(push_count));
    rd_ptr_next = pop ? wrap({1'b0, rd_ptr} + (PW+1)'(1)) : rd_ptr;
    level_next  = level + QW'(push_count) - QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_WR; k++) begin
      if (CW'(k) < push_count) begin
        mem[widx[k]] <= push_beats[k];
      end
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (level != '0);

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QW'(DEPTH))
    else $error("result queue level beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue popped while empty");

endmodule

>>> design/first_monotonic_run_extract.sv
// ----------------------------------------------------------------------------
// first_monotonic_run_extract
// Finds the first strictly rising or falling run of at least MIN_RUN samples
// in each sequence and streams its samples out, last one flagged.
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one signed sample per beat, with end_of_sequence
//   set on the final sample of a sequence. output channel carries the run's
//   samples in order, run_end on the last one, or a single no_run_found beat
//   (value zero) when a sequence ends without a qualifying run.
//   an input beat is taken in each cycle with in_stall low; its results (zero
//   to MIN_RUN beats) are registered into a result queue of 2*MIN_RUN
//   entries and appear on the output in order, one beat per cycle with out_stall low.
//   input stalls only while reset is high or the queue cannot take a full
//   burst of MIN_RUN beats, so sustained rate is one sample per cycle while
//   out_stall is low; the one burst per sequence drains at one beat per
//   unstalled cycle from the queue's single read port. a stalled receiver
//   just lets the queue fill; input stall follows from the registered queue
//   level, never from the output stall directly. synchronous reset empties
//   the queue and rearms the search; input is stalled while reset is high.
// ----------------------------------------------------------------------------
module first_monotonic_run_extract #(
  parameter int MIN_RUN = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  fmre_pkg::in_t  in_beat,
  output logic           out_valid,
  input  logic           out_stall,
  output fmre_pkg::out_t out_beat
);
  import fmre_pkg::*;

  localparam int DEPTH = 2 * MIN_RUN;
  localparam int LW    = $clog2(MIN_RUN + 1);
  localparam int IW    = $clog2(MIN_RUN);
  localparam int QW    = $clog2(DEPTH + 1);

  // search state
  phase_t        phase, phase_next;
  dir_t          dir, dir_next;
  logic [LW-1:0] len, len_next;
  sample_t       cand [MIN_RUN];
  sample_t       cand_next [MIN_RUN];
  // last sample of the candidate run; in the run phase the held sample
  sample_t       tail, tail_next;

  // per-beat decode
  logic          take;
  sample_t       cur;
  logic          last;
  logic          up, dn;
  dir_t          d;
  dir_t          dir_s;
  logic [LW-1:0] len_s;
  logic          found;
  logic          cont;

  // results of this beat
  out_t          res [MIN_RUN];
  logic [LW-1:0] res_n;

  // queue side
  logic          pop;
  logic          q_not_empty;
  logic [QW-1:0] q_level;

  assign in_stall = rst | (q_level > QW'(DEPTH - MIN_RUN));
  assign take     = in_valid & ~in_stall;
  assign cur      = in_beat.sample;
  assign last     = in_beat.end_of_sequence;

  // signed compare against the previous sample
  assign up   = (cur > tail);
  assign dn   = (cur < tail);
  assign d    = up ? DIR_UP : (dn ? DIR_DOWN : DIR_NONE);
  assign cont = (dir == DIR_UP) ? up : dn;

  // candidate run update while searching
  always_comb begin
    cand_next = cand;
    len_s     = len;
    dir_s     = dir;
    if (len == '0 || d == DIR_NONE) begin
      // fresh start, or equal neighbors break the run
      cand_next[0] = cur;
      len_s        = LW'(1);
      dir_s        = DIR_NONE;
    end else if (d == dir && len < LW'(MIN_RUN)) begin
      // run continues
      cand_next[len[IW-1:0]] = cur;
      len_s                  = len + LW'(1);
    end else begin
      // turning point: previous sample starts a new run
      cand_next[0] = tail;
      cand_next[1] = cur;
      len_s        = LW'(2);
      dir_s        = d;
    end
  end

  assign found = (len_s == LW'(MIN_RUN));

  // next state
  always_comb begin
    phase_next = phase;
    dir_next   = dir;
    len_next   = len;
    tail_next  = tail;
    if (take) begin
      case (phase)
        PH_SEARCH: begin
          // the newest sample is always the tail of the candidate
          tail_next = cur;
          len_next  = len_s;
          dir_next  = dir_s;
          if (last) begin
            phase_next = PH_SEARCH;
            len_next   = '0;
            dir_next   = DIR_NONE;
          end else if (found) begin
            phase_next = PH_RUN;
          end
        end
        PH_RUN: begin
          if (last) begin
            phase_next = PH_SEARCH;
            len_next   = '0;
            dir_next   = DIR_NONE;
          end else if (cont) begin
            tail_next = cur;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
          if (last) begin
            phase_next = PH_SEARCH;
            len_next   = '0;
            dir_next   = DIR_NONE;
          end
        end
        default: begin
          phase_next = PH_SEARCH;
          len_next   = '0;
          dir_next   = DIR_NONE;
        end
      endcase
    end
  end

  // result beats of the accepted sample
  always_comb begin
    for (int k = 0; k < MIN_RUN; k++) begin
      res[k] = '0;
    end
    res_n = '0;
    if (take) begin
      case (phase)
        PH_SEARCH: begin
          if (found) begin
            // whole run except its newest sample, which is held back unless the sequence ends here
            for (int k = 0; k < MIN_RUN - 1; k++) begin
              res[k] = '{run_value: cand_next[k], run_end: 1'b0, no_run_found: 1'b0};
            end
            if (last) begin
              res[MIN_RUN-1] = '{run_value: cur, run_end: 1'b1, no_run_found: 1'b0};
              res_n          = LW'(MIN_RUN);
            end else begin
              res_n = LW'(MIN_RUN - 1);
            end
          end else if (last) begin
            res[0] = '{run_value: '0, run_end: 1'b0, no_run_found: 1'b1};
            res_n  = LW'(1);
          end
        end
        PH_RUN: begin
          // held sample goes out, flagged if the run breaks here
          res[0] = '{run_value: tail, run_end: ~cont, no_run_found: 1'b0};
          if (cont && last) begin
            res[1] = '{run_value: cur, run_end: 1'b1, no_run_found: 1'b0};
            res_n  = LW'(2);
          end else begin
            res_n = LW'(1);
          end
        end
        default: begin
          res_n = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      dir   <= DIR_NONE;
      len   <= '0;
    end else begin
      phase <= phase_next;
      dir   <= dir_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    tail <= tail_next;
    if (take && phase == PH_SEARCH) begin
      cand <= cand_next;
    end
  end

  // output side
  assign pop       = q_not_empty & ~out_stall;
  assign out_valid = q_not_empty;

  fmre_result_queue #(
    .MAX_WR (MIN_RUN),
    .DEPTH  (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_n),
    .push_beats (res),
    .pop        (pop),
    .head       (out_beat),
    .not_empty  (q_not_empty),
    .level      (q_level)
  );

  a_run_len_full: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_SEARCH) |-> (len == LW'(MIN_RUN)))
    else $error("run phase entered without a full candidate run");

  a_short_no_dir: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEARCH && len <= LW'(1)) |-> (dir == DIR_NONE))
    else $error("direction set on a candidate shorter than two samples");

  a_no_run_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.no_run_found) |->
      (out_beat.run_value == '0 && !out_beat.run_end))
    else $error("no-run beat carries a value or end flag");

endmodule
